// ===== hdl/minmax_peak_decimator_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MINMAX_PEAK_DECIMATOR_UNIT_ASSERT_SVH
`define MINMAX_PEAK_DECIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define MMPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmpd check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define MMPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmpd check failed");

`endif

// ===== hdl/mmpd_pkg.sv =====
package mmpd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int INDEX_W   = 16;
  localparam int COUNTER_W = 25;
  localparam int STEP_W    = 24;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [INDEX_W-1:0]         index_t;
  typedef logic [COUNTER_W-1:0]       counter_t;
  typedef logic [STEP_W-1:0]          step_t;

  localparam index_t INDEX_TOP = '1;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_item_t;

  typedef struct packed {
    sample_t column_min;
    sample_t column_max;
    index_t  column_index;
    logic    column_last;
  } out_item_t;

  typedef struct packed {
    sample_t col_max;
    sample_t col_min;
  } col_range_t;

endpackage

// ===== hdl/mmpd_connect.sv =====
module mmpd_connect
  import mmpd_pkg::*;
(
  input  col_range_t prev_col,
  input  col_range_t new_col,
  output col_range_t adj_col
);

  typedef logic signed [19:0] wide_t;

  wide_t span_a, span_b, half_a, half_b, mid_diff, mid_abs;

  always_comb begin
    span_a = wide_t'(prev_col.col_max) - wide_t'(prev_col.col_min);
    span_b = wide_t'(new_col.col_max) - wide_t'(new_col.col_min);
    // halve with truncation toward zero
    half_a = (span_a + wide_t'({19'd0, span_a[19]})) >>> 1;
    half_b = (span_b + wide_t'({19'd0, span_b[19]})) >>> 1;
    mid_diff = (wide_t'(prev_col.col_min) + half_a) - (wide_t'(new_col.col_min) + half_b);
    mid_abs = mid_diff[19] ? -mid_diff : mid_diff;
    adj_col = new_col;
    if (mid_abs > half_a + half_b) begin
      if (!mid_diff[19] && (mid_diff != '0)) begin
        adj_col.col_max = prev_col.col_min;
      end else begin
        adj_col.col_min = prev_col.col_max;
      end
    end
  end

endmodule

// ===== hdl/minmax_peak_decimator_unit.sv =====
// Min/max peak decimator. Accepts one sample item per clock and returns one
// column item (min, max, index, last flag) each time the fractional sample
// counter (FRACTION_BITS fraction bits) reaches samples_per_column or a sample
// marked last arrives. Each sample is held in the input register, where
// the running min/max update, the counter compare and the column-connect adder
// and compare run in a single pass; a closing sample's column item is then
// written to the column register. With the result side ready, items flow
// one per cycle with no gaps; the input stalls only while a closing sample waits
// on a column item that has not been taken yet.
// samples_per_column values below 2.0 act as 2.0; write it only while idle.
module minmax_peak_decimator_unit
  import mmpd_pkg::*;
#(
  parameter int FRACTION_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_ready,
  input  in_item_t  sample_item,
  output logic      column_valid,
  input  logic      column_ready,
  output out_item_t column_item,
  input  logic      cfg_write,
  input  step_t     cfg_data
);

  localparam counter_t ONE_SAMPLE = counter_t'(1) << FRACTION_BITS;
  localparam step_t    MIN_STEP   = step_t'(2) << FRACTION_BITS;

  step_t      samples_per_column;
  logic       s1_valid;
  in_item_t   s1_item;
  counter_t   fraction_counter;
  sample_t    running_max, running_min;
  col_range_t previous_col;
  logic       column_open, run_started;
  index_t     column_number;

  sample_t    cur_max, cur_min;
  col_range_t prev_eff, new_col, adj_col;
  counter_t   count_inc;
  step_t      step_eff;
  logic       close_col, s1_advance;

  always_comb begin
    step_eff  = (samples_per_column < MIN_STEP) ? MIN_STEP : samples_per_column;
    count_inc = fraction_counter + ONE_SAMPLE;
    if (run_started) begin
      prev_eff = previous_col;
    end else begin
      prev_eff = '{col_max: s1_item.sample, col_min: s1_item.sample};
    end
    if (!column_open) begin
      cur_max = s1_item.sample;
      cur_min = s1_item.sample;
    end else begin
      cur_max = (s1_item.sample > running_max) ? s1_item.sample : running_max;
      cur_min = (s1_item.sample < running_min) ? s1_item.sample : running_min;
    end
    new_col    = '{col_max: cur_max, col_min: cur_min};
    close_col  = s1_item.last_sample || (count_inc >= {1'b0, step_eff});
    // an item that closes no column never waits on the result register
    s1_advance = s1_valid && (!close_col || !column_valid || column_ready);
  end

  assign sample_ready = !s1_valid || s1_advance;

  mmpd_connect u_connect (
    .prev_col (prev_eff),
    .new_col  (new_col),
    .adj_col  (adj_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_column <= MIN_STEP;
    end else if (cfg_write) begin
      samples_per_column <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_ready) begin
      s1_valid <= sample_valid;
    end
    if (sample_ready && sample_valid) begin
      s1_item <= sample_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fraction_counter <= '0;
      running_max      <= '0;
      running_min      <= '0;
      previous_col     <= '0;
      column_open      <= 1'b0;
      run_started      <= 1'b0;
      column_number    <= '0;
    end else if (s1_advance) begin
      running_max <= cur_max;
      running_min <= cur_min;
      if (!close_col) begin
        fraction_counter <= count_inc;
        previous_col     <= prev_eff;
        column_open      <= 1'b1;
        run_started      <= 1'b1;
      end else begin
        previous_col <= adj_col;
        column_open  <= 1'b0;
        if (s1_item.last_sample) begin
          fraction_counter <= '0;
          column_number    <= '0;
          run_started      <= 1'b0;
        end else begin
          fraction_counter <= count_inc - counter_t'(step_eff);
          run_started      <= 1'b1;
          if (column_number != INDEX_TOP) begin
            column_number <= column_number + index_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_valid <= 1'b0;
    end else if (s1_advance && close_col) begin
      column_valid <= 1'b1;
    end else if (column_ready) begin
      column_valid <= 1'b0;
    end
    if (s1_advance && close_col) begin
      column_item.column_min   <= adj_col.col_min;
      column_item.column_max   <= adj_col.col_max;
      column_item.column_index <= column_number;
      column_item.column_last  <= s1_item.last_sample;
    end
  end

endmodule

// ===== hdl/mmpd_checker.sv =====
`include "minmax_peak_decimator_unit_assert.svh"

module mmpd_checker
  import mmpd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      sample_valid,
  input logic      sample_ready,
  input in_item_t  sample_item,
  input logic      column_valid,
  input logic      column_ready,
  input out_item_t column_item
);

  index_t exp_index;

  // track the index the next column item must carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_index <= '0;
    end else if (column_valid && column_ready) begin
      if (column_item.column_last) begin
        exp_index <= '0;
      end else if (column_item.column_index != INDEX_TOP) begin
        exp_index <= column_item.column_index + index_t'(1);
      end
    end
  end

  `MMPD_ASSERT_NEXT(a_in_hold, sample_valid && !sample_ready, sample_valid && $stable(sample_item))
  `MMPD_ASSERT_NEXT(a_out_hold, column_valid && !column_ready, column_valid)
  `MMPD_ASSERT_NEXT(a_out_stable, column_valid && !column_ready, $stable(column_item))
  `MMPD_ASSERT_NOW(a_index_seq, column_valid, column_item.column_index == exp_index)
  `MMPD_ASSERT_NOW(a_stall_cause, !sample_ready, column_valid && !column_ready)

endmodule

bind minmax_peak_decimator_unit mmpd_checker u_mmpd_checker (.*);
